// ===== rtl/kalman_filter_two_state_assert.svh =====
// Assertion macros for the two-state Kalman filter.
`ifndef KALMAN_FILTER_TWO_STATE_ASSERT_SVH
`define KALMAN_FILTER_TWO_STATE_ASSERT_SVH
`ifndef SYNTHESIS
`define KF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/kf_pkg.sv =====
// ----------------------------------------------------------------------------
// kf_pkg: shared types and constants for the two-state Kalman filter
// Holds the operation codes, fixed-point constants and datapath command.
// ----------------------------------------------------------------------------
package kf_pkg;
    localparam int FRAC_BITS = 16;
    localparam int W = 32;
    localparam int ACC_W = 72;

    localparam logic [1:0] FUNC_PREDICT = 2'd0;
    localparam logic [1:0] FUNC_UPDATE  = 2'd1;
    localparam logic [1:0] FUNC_BOTH    = 2'd2;
    localparam logic [1:0] FUNC_LOAD    = 2'd3;

    localparam logic [2:0] REG_A_TOP = 3'd0;
    localparam logic [2:0] REG_A_BOT = 3'd1;
    localparam logic [2:0] REG_B     = 3'd2;
    localparam logic [2:0] REG_H     = 3'd3;
    localparam logic [2:0] REG_Q_TOP = 3'd4;
    localparam logic [2:0] REG_Q_BOT = 3'd5;
    localparam logic [2:0] REG_R     = 3'd6;

    // Micro-operation steps executed by the datapath, one per cycle
    // except the divides, which the divider runs bit-serially.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_X0   = 5'd0;
    localparam logic [STEP_W-1:0] ST_X1   = 5'd1;
    localparam logic [STEP_W-1:0] ST_M00  = 5'd2;
    localparam logic [STEP_W-1:0] ST_M01  = 5'd3;
    localparam logic [STEP_W-1:0] ST_M10  = 5'd4;
    localparam logic [STEP_W-1:0] ST_M11  = 5'd5;
    localparam logic [STEP_W-1:0] ST_P00  = 5'd6;
    localparam logic [STEP_W-1:0] ST_P01  = 5'd7;
    localparam logic [STEP_W-1:0] ST_P10  = 5'd8;
    localparam logic [STEP_W-1:0] ST_P11  = 5'd9;
    localparam logic [STEP_W-1:0] ST_HX   = 5'd10;
    localparam logic [STEP_W-1:0] ST_Y    = 5'd11;
    localparam logic [STEP_W-1:0] ST_PH0  = 5'd12;
    localparam logic [STEP_W-1:0] ST_PH1  = 5'd13;
    localparam logic [STEP_W-1:0] ST_S    = 5'd14;
    localparam logic [STEP_W-1:0] ST_HP0  = 5'd15;
    localparam logic [STEP_W-1:0] ST_HP1  = 5'd16;
    localparam logic [STEP_W-1:0] ST_K0   = 5'd17;
    localparam logic [STEP_W-1:0] ST_K1   = 5'd18;
    localparam logic [STEP_W-1:0] ST_UX0  = 5'd19;
    localparam logic [STEP_W-1:0] ST_UX1  = 5'd20;
    localparam logic [STEP_W-1:0] ST_UP00 = 5'd21;
    localparam logic [STEP_W-1:0] ST_UP01 = 5'd22;
    localparam logic [STEP_W-1:0] ST_UP10 = 5'd23;
    localparam logic [STEP_W-1:0] ST_UP11 = 5'd24;
    localparam logic [STEP_W-1:0] ST_LOAD = 5'd25;
    localparam logic [STEP_W-1:0] ST_CLR  = 5'd26;

    typedef struct packed {
        logic              exec;
        logic [STEP_W-1:0] step;
        logic              div_start;
    } kf_cmd_t;

    typedef struct packed {
        logic div_done;
        logic s_bad;
    } kf_status_t;

    // Rounded fixed-point product, half up.
    function automatic logic signed [ACC_W-1:0] fmul(input logic signed [W-1:0] a,
                                                     input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        begin
            p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
            fmul = ACC_W'(p >>> FRAC_BITS);
        end
    endfunction
endpackage

// ===== rtl/kf_divider.sv =====
// ----------------------------------------------------------------------------
// kf_divider: bit-serial signed divider
// Computes trunc((num * 2^FRAC_BITS) / den) for a positive den, one quotient
// bit per cycle, and returns the unclipped quotient.
// ----------------------------------------------------------------------------
module kf_divider
    import kf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [W-1:0]     num,
    input  logic signed [W-1:0]     den,
    output logic                    done,
    output logic signed [ACC_W-1:0] quot
);
    localparam int NB = W + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] dividend_reg, dividend_next;
    logic [NB:0]   rem_reg, rem_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NB:0]   trial;
    logic [NB-1:0] mag;

    // Restoring division over the magnitude.
    always_comb
    begin
        dividend_next = dividend_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mag = '0;
        trial = '0;
        if (start)
        begin
            mag = num[W-1] ? NB'(-$signed({num[W-1], num})) << FRAC_BITS
                           : NB'(num) << FRAC_BITS;
            dividend_next = mag;
            rem_next = '0;
            den_next = den;
            neg_next = num[W-1];
            cnt_next = CW'(NB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[NB-1:0], dividend_reg[NB-1]};
            if (trial >= (NB+1)'(den_reg))
            begin
                rem_next = trial - (NB+1)'(den_reg);
                dividend_next = {dividend_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                dividend_next = {dividend_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(ACC_W'(dividend_reg)) : $signed(ACC_W'(dividend_reg));
endmodule

// ===== rtl/kf_datapath.sv =====
// ----------------------------------------------------------------------------
// kf_datapath: registers and arithmetic of the filter
// Holds model registers, state, covariance and intermediates; executes one
// micro-operation per command with at most three products and a saturating sum.
// ----------------------------------------------------------------------------
module kf_datapath
    import kf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  kf_cmd_t             cmd,
    input  logic signed [W-1:0] in_u,
    input  logic signed [W-1:0] in_z,
    input  logic signed [W-1:0] in_init [6],
    output kf_status_t          status,
    output logic signed [W-1:0] x_out [2],
    output logic signed [W-1:0] p_out [4],
    output logic                sat_out
);
    localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] MINV = -ACC_W'(64'sd2147483648);

    logic signed [W-1:0] a00_reg, a01_reg, a10_reg, a11_reg, b0_reg, b1_reg;
    logic signed [W-1:0] h0_reg, h1_reg, q00_reg, q01_reg, q10_reg, q11_reg;
    logic [30:0]         r_reg;
    logic signed [W-1:0] x_reg [2];
    logic signed [W-1:0] p_reg [4];
    logic signed [W-1:0] m_reg [4];
    logic signed [W-1:0] hx_reg, y_reg, ph0_reg, ph1_reg, s_reg, hp0_reg, hp1_reg;
    logic signed [W-1:0] k0_reg, k1_reg, nx0_reg;
    logic                sat_reg;
    logic signed [W-1:0] u_reg, z_reg;
    logic signed [W-1:0] init_reg [6];

    logic signed [W-1:0]     opa0, opb0, opa1, opb1, opc;
    logic signed [ACC_W-1:0] sum, raw;
    logic signed [W-1:0]     res;
    logic                    clipped;
    logic                    div_start;
    logic signed [W-1:0]     div_num;
    logic                    div_done;
    logic signed [ACC_W-1:0] div_q;
    logic                    use_div;

    kf_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // The second division is started while the first gain is being stored.
    assign div_start = cmd.div_start;
    assign div_num = (cmd.step == ST_K0) ? ph1_reg : ph0_reg;

    // The item operands are held from the input transfer to the end of the item.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && cmd.step == ST_CLR)
        begin
            u_reg <= in_u;
            z_reg <= in_z;
            init_reg <= in_init;
        end
    end

    // Operand selection for the current micro-operation.
    always_comb
    begin
        opa0 = '0; opb0 = '0; opa1 = '0; opb1 = '0; opc = '0; use_div = 1'b0;
        case (cmd.step)
            ST_X0:  begin opa0 = a00_reg; opb0 = x_reg[0]; opa1 = a01_reg; opb1 = x_reg[1]; end
            ST_X1:  begin opa0 = a10_reg; opb0 = x_reg[0]; opa1 = a11_reg; opb1 = x_reg[1]; end
            ST_M00: begin opa0 = a00_reg; opb0 = p_reg[0]; opa1 = a01_reg; opb1 = p_reg[2]; end
            ST_M01: begin opa0 = a00_reg; opb0 = p_reg[1]; opa1 = a01_reg; opb1 = p_reg[3]; end
            ST_M10: begin opa0 = a10_reg; opb0 = p_reg[0]; opa1 = a11_reg; opb1 = p_reg[2]; end
            ST_M11: begin opa0 = a10_reg; opb0 = p_reg[1]; opa1 = a11_reg; opb1 = p_reg[3]; end
            ST_P00: begin opa0 = m_reg[0]; opb0 = a00_reg; opa1 = m_reg[1]; opb1 = a01_reg;
                          opc = q00_reg; end
            ST_P01: begin opa0 = m_reg[0]; opb0 = a10_reg; opa1 = m_reg[1]; opb1 = a11_reg;
                          opc = q01_reg; end
            ST_P10: begin opa0 = m_reg[2]; opb0 = a00_reg; opa1 = m_reg[3]; opb1 = a01_reg;
                          opc = q10_reg; end
            ST_P11: begin opa0 = m_reg[2]; opb0 = a10_reg; opa1 = m_reg[3]; opb1 = a11_reg;
                          opc = q11_reg; end
            ST_HX:  begin opa0 = h0_reg; opb0 = x_reg[0]; opa1 = h1_reg; opb1 = x_reg[1]; end
            ST_PH0: begin opa0 = p_reg[0]; opb0 = h0_reg; opa1 = p_reg[1]; opb1 = h1_reg; end
            ST_PH1: begin opa0 = p_reg[2]; opb0 = h0_reg; opa1 = p_reg[3]; opb1 = h1_reg; end
            ST_S:   begin opa0 = h0_reg; opb0 = ph0_reg; opa1 = h1_reg; opb1 = ph1_reg;
                          opc = $signed({1'b0, r_reg}); end
            ST_HP0: begin opa0 = h0_reg; opb0 = p_reg[0]; opa1 = h1_reg; opb1 = p_reg[2]; end
            ST_HP1: begin opa0 = h0_reg; opb0 = p_reg[1]; opa1 = h1_reg; opb1 = p_reg[3]; end
            ST_K0, ST_K1: use_div = 1'b1;
            ST_UX0: begin opa0 = k0_reg; opb0 = y_reg; opc = x_reg[0]; end
            ST_UX1: begin opa0 = k1_reg; opb0 = y_reg; opc = x_reg[1]; end
            ST_UP00: begin opa0 = -k0_reg; opb0 = hp0_reg; opc = p_reg[0]; end
            ST_UP01: begin opa0 = -k0_reg; opb0 = hp1_reg; opc = p_reg[1]; end
            ST_UP10: begin opa0 = -k1_reg; opb0 = hp0_reg; opc = p_reg[2]; end
            ST_UP11: begin opa0 = -k1_reg; opb0 = hp1_reg; opc = p_reg[3]; end
            default: ;
        endcase
    end

    // Sum of rounded products and saturation; subtraction steps select -k, which
    // is negated back to k before the rounded product k*hp is subtracted.
    always_comb
    begin
        if (use_div)
            sum = div_q;
        else if (cmd.step == ST_Y)
            sum = ACC_W'(z_reg) - ACC_W'(hx_reg);
        else if (cmd.step == ST_UP00 || cmd.step == ST_UP01 ||
                 cmd.step == ST_UP10 || cmd.step == ST_UP11)
            sum = ACC_W'(opc) - fmul(-opa0, opb0);
        else
            sum = fmul(opa0, opb0) + fmul(opa1, opb1) + ACC_W'(opc);
        raw = sum;
        clipped = (raw > MAXV) || (raw < MINV);
        if (raw > MAXV)
            res = W'(MAXV);
        else if (raw < MINV)
            res = W'(MINV);
        else
            res = W'(raw);
    end

    assign status.div_done = div_done;
    assign status.s_bad = (s_reg <= 0);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a00_reg <= '0; a01_reg <= '0; a10_reg <= '0; a11_reg <= '0;
            b0_reg <= '0; b1_reg <= '0; h0_reg <= '0; h1_reg <= '0;
            q00_reg <= '0; q01_reg <= '0; q10_reg <= '0; q11_reg <= '0;
            r_reg <= 31'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_A_TOP: begin a00_reg <= cfg_data[63:32]; a01_reg <= cfg_data[31:0]; end
                REG_A_BOT: begin a10_reg <= cfg_data[63:32]; a11_reg <= cfg_data[31:0]; end
                REG_B:     begin b0_reg <= cfg_data[63:32]; b1_reg <= cfg_data[31:0]; end
                REG_H:     begin h0_reg <= cfg_data[63:32]; h1_reg <= cfg_data[31:0]; end
                REG_Q_TOP: begin q00_reg <= cfg_data[63:32]; q01_reg <= cfg_data[31:0]; end
                REG_Q_BOT: begin q10_reg <= cfg_data[63:32]; q11_reg <= cfg_data[31:0]; end
                REG_R:     r_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Control input term of the state predict, added by a separate saturating sum.
    logic signed [ACC_W-1:0] bu0, bu1;
    assign bu0 = fmul(b0_reg, u_reg);
    assign bu1 = fmul(b1_reg, u_reg);
    logic signed [ACC_W-1:0] xs_raw;
    logic signed [W-1:0]     xs_res;
    logic                    xs_clip;
    always_comb
    begin
        xs_raw = sum + ((cmd.step == ST_X0) ? bu0 : bu1);
        xs_clip = (xs_raw > MAXV) || (xs_raw < MINV);
        if (xs_raw > MAXV)
            xs_res = W'(MAXV);
        else if (xs_raw < MINV)
            xs_res = W'(MINV);
        else
            xs_res = W'(xs_raw);
    end

    // State, covariance and intermediate registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg[0] <= '0; x_reg[1] <= '0;
            p_reg[0] <= '0; p_reg[1] <= '0; p_reg[2] <= '0; p_reg[3] <= '0;
            sat_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            if (cmd.step == ST_X0 || cmd.step == ST_X1)
            begin
                if (xs_clip)
                    sat_reg <= 1'b1;
            end
            else if (cmd.step != ST_LOAD && cmd.step != ST_CLR && clipped)
                sat_reg <= 1'b1;
            case (cmd.step)
                ST_CLR:  sat_reg <= 1'b0;
                ST_LOAD:
                begin
                    x_reg[0] <= init_reg[0]; x_reg[1] <= init_reg[1];
                    p_reg[0] <= init_reg[2]; p_reg[1] <= init_reg[3];
                    p_reg[2] <= init_reg[4]; p_reg[3] <= init_reg[5];
                end
                ST_X0:   nx0_reg <= xs_res;
                ST_X1:   begin x_reg[0] <= nx0_reg; x_reg[1] <= xs_res; end
                ST_M00:  m_reg[0] <= res;
                ST_M01:  m_reg[1] <= res;
                ST_M10:  m_reg[2] <= res;
                ST_M11:  m_reg[3] <= res;
                ST_P00:  p_reg[0] <= res;
                ST_P01:  p_reg[1] <= res;
                ST_P10:  p_reg[2] <= res;
                ST_P11:  p_reg[3] <= res;
                ST_HX:   hx_reg <= res;
                ST_Y:    y_reg <= res;
                ST_PH0:  ph0_reg <= res;
                ST_PH1:  ph1_reg <= res;
                ST_S:    s_reg <= res;
                ST_HP0:  hp0_reg <= res;
                ST_HP1:  hp1_reg <= res;
                ST_K0:   k0_reg <= res;
                ST_K1:   k1_reg <= res;
                ST_UX0:  x_reg[0] <= res;
                ST_UX1:  x_reg[1] <= res;
                ST_UP00: p_reg[0] <= res;
                ST_UP01: p_reg[1] <= res;
                ST_UP10: p_reg[2] <= res;
                ST_UP11: p_reg[3] <= res;
                default: ;
            endcase
        end
    end

    assign x_out = x_reg;
    assign p_out = p_reg;
    assign sat_out = sat_reg;
endmodule

// ===== rtl/kf_control.sv =====
// ----------------------------------------------------------------------------
// kf_control: sequencer of the filter
// Accepts an item, steps the datapath through the load, predict and update
// micro-operations, waits on the divider, and presents the result.
// ----------------------------------------------------------------------------
module kf_control
    import kf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_func,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_singular,
    output kf_cmd_t    cmd,
    input  kf_status_t status
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        func_reg, func_next;
    logic              sing_reg, sing_next;
    logic              wait_reg, wait_next;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_singular = sing_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        func_next = func_reg;
        sing_next = sing_reg;
        wait_next = 1'b0;
        cmd.exec = 1'b0;
        cmd.step = step_reg;
        cmd.div_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.step = ST_CLR;
                if (in_valid)
                begin
                    cmd.exec = 1'b1;
                    func_next = in_func;
                    sing_next = 1'b0;
                    state_next = S_RUN;
                    if (in_func == FUNC_LOAD)
                        step_next = ST_LOAD;
                    else if (in_func == FUNC_UPDATE)
                        step_next = ST_HX;
                    else
                        step_next = ST_X0;
                end
            end
            S_RUN:
            begin
                cmd.exec = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == ST_LOAD || (step_reg == ST_P11 && func_reg == FUNC_PREDICT)
                    || step_reg == ST_UP11)
                    state_next = S_DONE;
                else if (step_reg == ST_HP0 && status.s_bad)
                begin
                    // The innovation variance is known here; skip the rest of the update.
                    cmd.exec = 1'b0;
                    sing_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (step_reg == ST_HP1)
                begin
                    cmd.div_start = 1'b1;
                    step_next = ST_K0;
                    state_next = S_DIV;
                    wait_next = 1'b1;
                end
            end
            S_DIV:
            begin
                if (status.div_done && !wait_reg)
                begin
                    cmd.exec = 1'b1;
                    if (step_reg == ST_K0)
                    begin
                        cmd.div_start = 1'b1;
                        wait_next = 1'b1;
                        step_next = ST_K1;
                    end
                    else
                    begin
                        step_next = ST_UX0;
                        state_next = S_RUN;
                    end
                end
            end
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            func_reg <= '0;
            sing_reg <= 1'b0;
            wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            func_reg <= func_next;
            sing_reg <= sing_next;
            wait_reg <= wait_next;
        end
    end
endmodule

// ===== rtl/kalman_filter_two_state.sv =====
// Operations: load, predict, update and predict then update; an update forms its gain with
// two serial divisions of 48 quotient bits, and is cut short when the innovation variance
// is not positive.
// Flow: one item at a time; the next input transfer can follow in the cycle after the
// output transfer.
// Reset: asynchronous active low; state and covariance clear, model registers clear except R.
// ----------------------------------------------------------------------------
// kalman_filter_two_state: two-state fixed-point Kalman filter
// Streaming top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
`include "kalman_filter_two_state_assert.svh"
module kalman_filter_two_state
    import kf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // control_u, measurement_z, init_pos, init_vel, init_p00, init_p01, init_p10, init_p11
    input  logic [255:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // est_pos, est_vel, cov_00, cov_01, cov_10, cov_11
    output logic [191:0] m_axis_tdata,
    // singular, saturated
    output logic [1:0]   m_axis_tuser
);
    kf_cmd_t             cmd;
    kf_status_t          status;
    logic signed [W-1:0] init_v [6];
    logic signed [W-1:0] x_v [2];
    logic signed [W-1:0] p_v [4];
    logic                sat;
    logic                sing;

    assign init_v[0] = s_axis_tdata[95:64];
    assign init_v[1] = s_axis_tdata[127:96];
    assign init_v[2] = s_axis_tdata[159:128];
    assign init_v[3] = s_axis_tdata[191:160];
    assign init_v[4] = s_axis_tdata[223:192];
    assign init_v[5] = s_axis_tdata[255:224];

    kf_control u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_func      (s_axis_tuser),
        .in_ready     (s_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_singular (sing),
        .cmd          (cmd),
        .status       (status)
    );

    kf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .in_u      (s_axis_tdata[31:0]),
        .in_z      (s_axis_tdata[63:32]),
        .in_init   (init_v),
        .status    (status),
        .x_out     (x_v),
        .p_out     (p_v),
        .sat_out   (sat)
    );

    assign m_axis_tdata = {p_v[3], p_v[2], p_v[1], p_v[0], x_v[1], x_v[0]};
    assign m_axis_tuser = {sat, sing};

    // A stalled result holds until taken.
    `KF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // No new item is taken while a result waits.
    `KF_ASSERT_IMPL(a_no_overlap, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    // A load never reports a singular update.
    `KF_ASSERT_NEXT(a_load_nosing, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_LOAD, !m_axis_tuser[0])
endmodule

// ===== tb/sv/tb_kalman_filter_two_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kalman_filter_two_state: self-checking bench for the two-state filter
// Drives filter operations over the input stream, keeps its own fixed-point
// model of the estimate and covariance, and checks every output transfer.
// ----------------------------------------------------------------------------
module tb_kalman_filter_two_state
    import kf_pkg::*;
();

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 160;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    // One directed row: either a register write or an operation.
    typedef struct {
        bit           is_cfg;
        logic [2:0]   idx;
        logic [63:0]  val;
        logic [1:0]   op;
        logic [255:0] payload;
        bit           typed;
        logic [193:0] want;
    } stim_row_t;

    // Filter model state and registers, all as 64-bit signed values.
    longint mdl_a[4];
    longint mdl_b[2];
    longint mdl_h[2];
    longint mdl_q[4];
    longint mdl_r;
    longint est_x[2];
    longint est_p[4];
    bit     clip_hit;

    // Expected {saturated, singular, tdata} words, oldest first.
    logic [193:0] pending_est[$];
    stim_row_t    stim_table[$];
    int           errors;
    int           idle_cycles;
    int           burst_left;
    bit           hold_req;

    kalman_filter_two_state DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rounded fixed-point product, half up.
    function automatic longint qmul(longint a, longint b);
        return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // Saturate to 32 bits and note any clipping.
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
        begin
            clip_hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            clip_hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    // Time update: x = A*x + B*u, P = A*P*A^T + Q.
    function automatic void predict_step(longint u);
        longint x0, x1, m00, m01, m10, m11;
        x0 = est_x[0];
        x1 = est_x[1];
        est_x[0] = clamp32(qmul(mdl_a[0], x0) + qmul(mdl_a[1], x1) + qmul(mdl_b[0], u));
        est_x[1] = clamp32(qmul(mdl_a[2], x0) + qmul(mdl_a[3], x1) + qmul(mdl_b[1], u));
        m00 = clamp32(qmul(mdl_a[0], est_p[0]) + qmul(mdl_a[1], est_p[2]));
        m01 = clamp32(qmul(mdl_a[0], est_p[1]) + qmul(mdl_a[1], est_p[3]));
        m10 = clamp32(qmul(mdl_a[2], est_p[0]) + qmul(mdl_a[3], est_p[2]));
        m11 = clamp32(qmul(mdl_a[2], est_p[1]) + qmul(mdl_a[3], est_p[3]));
        est_p[0] = clamp32(qmul(m00, mdl_a[0]) + qmul(m01, mdl_a[1]) + mdl_q[0]);
        est_p[1] = clamp32(qmul(m00, mdl_a[2]) + qmul(m01, mdl_a[3]) + mdl_q[1]);
        est_p[2] = clamp32(qmul(m10, mdl_a[0]) + qmul(m11, mdl_a[1]) + mdl_q[2]);
        est_p[3] = clamp32(qmul(m10, mdl_a[2]) + qmul(m11, mdl_a[3]) + mdl_q[3]);
    endfunction

    // Measurement update; returns 1 when the innovation variance is not positive.
    function automatic bit update_step(longint z);
        longint hx, y, ph0, ph1, s, k0, k1, hp0, hp1;
        hx  = clamp32(qmul(mdl_h[0], est_x[0]) + qmul(mdl_h[1], est_x[1]));
        y   = clamp32(z - hx);
        ph0 = clamp32(qmul(est_p[0], mdl_h[0]) + qmul(est_p[1], mdl_h[1]));
        ph1 = clamp32(qmul(est_p[2], mdl_h[0]) + qmul(est_p[3], mdl_h[1]));
        s   = clamp32(qmul(mdl_h[0], ph0) + qmul(mdl_h[1], ph1) + mdl_r);
        if (s <= 0)
            return 1'b1;
        k0 = clamp32((ph0 * (64'sd1 <<< FRAC_BITS)) / s);
        k1 = clamp32((ph1 * (64'sd1 <<< FRAC_BITS)) / s);
        est_x[0] = clamp32(est_x[0] + qmul(k0, y));
        est_x[1] = clamp32(est_x[1] + qmul(k1, y));
        hp0 = clamp32(qmul(mdl_h[0], est_p[0]) + qmul(mdl_h[1], est_p[2]));
        hp1 = clamp32(qmul(mdl_h[0], est_p[1]) + qmul(mdl_h[1], est_p[3]));
        est_p[0] = clamp32(est_p[0] - qmul(k0, hp0));
        est_p[1] = clamp32(est_p[1] - qmul(k0, hp1));
        est_p[2] = clamp32(est_p[2] - qmul(k1, hp0));
        est_p[3] = clamp32(est_p[3] - qmul(k1, hp1));
        return 1'b0;
    endfunction

    // Apply one operation to the model and return the expected output word.
    function automatic logic [193:0] filter_step(logic [1:0] op, logic [255:0] pl);
        bit sing;
        sing = 1'b0;
        clip_hit = 1'b0;
        case (op)
            FUNC_PREDICT: predict_step(sx(pl[31:0]));
            FUNC_UPDATE:  sing = update_step(sx(pl[63:32]));
            FUNC_BOTH:
            begin
                predict_step(sx(pl[31:0]));
                sing = update_step(sx(pl[63:32]));
            end
            default:
            begin
                est_x[0] = sx(pl[95:64]);
                est_x[1] = sx(pl[127:96]);
                for (int i = 0; i < 4; i++)
                    est_p[i] = sx(pl[128 + 32*i +: 32]);
            end
        endcase
        return {clip_hit, sing, est_p[3][31:0], est_p[2][31:0], est_p[1][31:0],
                est_p[0][31:0], est_x[1][31:0], est_x[0][31:0]};
    endfunction

    function automatic logic [255:0] pack_item(logic [31:0] u, logic [31:0] z,
                                               logic [31:0] pos, logic [31:0] vel,
                                               logic [31:0] p00, logic [31:0] p01,
                                               logic [31:0] p10, logic [31:0] p11);
        return {p11, p10, p01, p00, vel, pos, z, u};
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [63:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        stim_table = {stim_table, r};
    endfunction

    function automatic void add_op(logic [1:0] op, logic [255:0] pl, bit typed,
                                   logic [193:0] want);
        stim_row_t r;
        r = '{default: '0};
        r.op = op;
        r.payload = pl;
        r.typed = typed;
        r.want = want;
        stim_table = {stim_table, r};
    endfunction

    // Mostly modest Q16.16 values, sometimes full 32-bit range.
    function automatic logic [31:0] rnd_val(bit wide);
        if (wide || $urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endfunction

    // Register write at the falling edge, mirrored into the model.
    task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_A_TOP: begin mdl_a[0] = sx(val[63:32]); mdl_a[1] = sx(val[31:0]); end
            REG_A_BOT: begin mdl_a[2] = sx(val[63:32]); mdl_a[3] = sx(val[31:0]); end
            REG_B:     begin mdl_b[0] = sx(val[63:32]); mdl_b[1] = sx(val[31:0]); end
            REG_H:     begin mdl_h[0] = sx(val[63:32]); mdl_h[1] = sx(val[31:0]); end
            REG_Q_TOP: begin mdl_q[0] = sx(val[63:32]); mdl_q[1] = sx(val[31:0]); end
            REG_Q_BOT: begin mdl_q[2] = sx(val[63:32]); mdl_q[3] = sx(val[31:0]); end
            REG_R:     mdl_r = longint'(val[30:0]);
            default:   ;
        endcase
    endtask

    // Wait until the filter has delivered everything and gone quiet.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_est.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one operation, wait for its transfer, then maybe end the burst.
    task automatic send_op(logic [1:0] op, logic [255:0] pl, bit typed, logic [193:0] want);
        logic [193:0] model_word;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pl;
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        model_word = filter_step(op, pl);
        pending_est = {pending_est, (typed ? want : model_word)};
        if (burst_left == 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        else
            burst_left--;
    endtask

    // Model settings for the random phases.
    task automatic write_setting(int k);
        case (k)
            0, 3:
            begin
                // Constant-velocity model with a step of 0.1.
                cfg_write(REG_A_TOP, {32'h0001_0000, 32'h0000_1999});
                cfg_write(REG_A_BOT, {32'h0000_0000, 32'h0001_0000});
                cfg_write(REG_B,     {32'h0000_0147, 32'h0000_1999});
                cfg_write(REG_H,     {32'h0001_0000, 32'h0000_0000});
                cfg_write(REG_Q_TOP, {32'h0000_0040, 32'h0000_0000});
                cfg_write(REG_Q_BOT, {32'h0000_0000, 32'h0000_0040});
                cfg_write(REG_R, (k == 3) ? 64'd0 : 64'($urandom_range(1, 32'h0008_0000)));
            end
            1:
            begin
                cfg_write(REG_A_TOP, {$urandom, $urandom});
                cfg_write(REG_A_BOT, {$urandom, $urandom});
                cfg_write(REG_B,     {$urandom, $urandom});
                cfg_write(REG_H,     {$urandom, $urandom});
                cfg_write(REG_Q_TOP, {$urandom, $urandom});
                cfg_write(REG_Q_BOT, {$urandom, $urandom});
                cfg_write(REG_R,     {$urandom, $urandom});
            end
            default:
            begin
                // Extreme coefficients everywhere.
                cfg_write(REG_A_TOP, {32'h7FFF_FFFF, 32'h8000_0000});
                cfg_write(REG_A_BOT, {32'h8000_0000, 32'h7FFF_FFFF});
                cfg_write(REG_B,     {32'h7FFF_FFFF, 32'h8000_0000});
                cfg_write(REG_H,     {32'h8000_0000, 32'h7FFF_FFFF});
                cfg_write(REG_Q_TOP, {32'h7FFF_FFFF, 32'h8000_0000});
                cfg_write(REG_Q_BOT, {32'h8000_0000, 32'h7FFF_FFFF});
                cfg_write(REG_R,     64'h0000_0000_7FFF_FFFF);
            end
        endcase
    endtask

    // Receiver: long hold on request, otherwise rotating stall patterns.
    initial
    begin
        int cyc;
        cyc = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                case ((cyc / 97) % 3)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) < 3);
                endcase
        end
    end

    // Output checking and the stall watchdog.
    always @(posedge clk)
    begin
        logic [193:0] exp_word;
        logic [193:0] got_word;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_word = {m_axis_tuser[1], m_axis_tuser[0], m_axis_tdata};
                if (pending_est.size() == 0)
                begin
                    $display("%0t: unexpected output transfer %h", $time, got_word);
                    errors++;
                end
                else
                begin
                    exp_word = pending_est.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (got_word[32*i +: 32] !== exp_word[32*i +: 32])
                        begin
                            $display("%0t: output field %0d expected %h actual %h",
                                     $time, i, exp_word[32*i +: 32], got_word[32*i +: 32]);
                            errors++;
                        end
                    if (got_word[192] !== exp_word[192])
                    begin
                        $display("%0t: singular expected %b actual %b",
                                 $time, exp_word[192], got_word[192]);
                        errors++;
                    end
                    if (got_word[193] !== exp_word[193])
                    begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, exp_word[193], got_word[193]);
                        errors++;
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial
    begin
        logic [1:0]   op;
        logic [255:0] pl;
        int           sent;
        int           r;
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        hold_req = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        mdl_a = '{0, 0, 0, 0};
        mdl_b = '{0, 0};
        mdl_h = '{0, 0};
        mdl_q = '{0, 0, 0, 0};
        mdl_r = 65536;
        est_x = '{0, 0};
        est_p = '{0, 0, 0, 0};

        // Directed table; rows with a typed result follow from reset values.
        add_op(FUNC_PREDICT, pack_item(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
        add_op(FUNC_UPDATE, pack_item(0, 32'h8000_0000, 0, 0, 0, 0, 0, 0), 1'b1, '0);
        add_op(FUNC_LOAD, pack_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF), 1'b1,
               {2'b00, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF});
        add_op(FUNC_LOAD, pack_item(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h1), 1'b1,
               {2'b00, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                32'h7FFF_FFFF, 32'h8000_0000});
        add_cfg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        add_op(FUNC_BOTH, pack_item(32'h1, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
        // Zero measurement noise with zero covariance: update is skipped.
        add_cfg(REG_R, 64'd0);
        add_op(FUNC_UPDATE, pack_item(0, 32'h5, 0, 0, 0, 0, 0, 0), 1'b1,
               {2'b01, 192'd0});
        add_cfg(REG_A_TOP, {32'h0002_0000, 32'h0000_0000});
        add_cfg(REG_A_BOT, {32'h0000_0000, 32'h0002_0000});
        add_cfg(REG_B,     {32'h0001_0000, 32'h0000_8000});
        add_cfg(REG_H,     {32'h0001_0000, 32'h0000_0000});
        add_cfg(REG_Q_TOP, {32'h0000_0100, 32'h0000_0000});
        add_cfg(REG_Q_BOT, {32'h0000_0000, 32'h0000_0100});
        add_cfg(REG_R,     64'h0001_0000);
        add_op(FUNC_LOAD, pack_item(0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
               0, 0, 32'h0001_0000), 1'b0, '0);
        add_op(FUNC_PREDICT, pack_item(32'h0002_0000, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_op(FUNC_UPDATE, pack_item(0, 32'h0003_0000, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_op(FUNC_BOTH, pack_item(32'hFFFF_0000, 32'h0001_8000, 0, 0, 0, 0, 0, 0),
               1'b0, '0);
        // Near-full-scale state: doubling saturates.
        add_op(FUNC_LOAD, pack_item(0, 0, 32'h7FFF_0000, 32'h8001_0000, 32'h7FFF_0000,
               32'h7FFF_0000, 32'h8001_0000, 32'h7FFF_0000), 1'b0, '0);
        add_op(FUNC_PREDICT, pack_item(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_op(FUNC_UPDATE, pack_item(0, 32'h8000_0000, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        // Negative covariance drives the innovation variance below zero.
        add_op(FUNC_LOAD, pack_item(0, 0, 32'h0001_0000, 0, 32'hFF9C_0000, 0, 0,
               32'h0001_0000), 1'b0, '0);
        add_op(FUNC_UPDATE, pack_item(0, 32'h0002_0000, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_cfg(REG_R, 64'hFFFF_FFFF_FFFF_FFFF);
        add_op(FUNC_BOTH, pack_item(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0),
               1'b0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
            begin
                wait_idle();
                cfg_write(stim_table[i].idx, stim_table[i].val);
            end
            else
                send_op(stim_table[i].op, stim_table[i].payload, stim_table[i].typed,
                        stim_table[i].want);
        end

        // Random phases: well-formed filter runs opened by a load.
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            write_setting(ph);
            for (int i = 0; i < 500; i++)
            begin
                r = $urandom_range(0, 9);
                if (i == 0 || r == 0)
                    op = FUNC_LOAD;
                else if (r <= 3)
                    op = FUNC_PREDICT;
                else if (r <= 6)
                    op = FUNC_UPDATE;
                else
                    op = FUNC_BOTH;
                pl = pack_item(rnd_val(ph == 1), rnd_val(ph == 1), rnd_val(ph == 1),
                               rnd_val(ph == 1), rnd_val(ph == 1), rnd_val(0),
                               rnd_val(0), rnd_val(ph == 1));
                if (sent == 150)
                    hold_req = 1'b1;
                if (sent == 800)
                begin
                    // Let the filter drain completely before going on.
                    @(negedge clk);
                    s_axis_tvalid <= 1'b0;
                    wait (pending_est.size() == 0);
                end
                send_op(op, pl, 1'b0, '0);
                sent++;
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_est.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kf_pkg.sv
rtl/kf_divider.sv
rtl/kf_datapath.sv
rtl/kf_control.sv
rtl/kalman_filter_two_state.sv
tb/sv/tb_kalman_filter_two_state.sv
